### src/lobt_pkg.sv
// lobt_pkg: types and constants shared by the order book table modules
// no dependencies
package lobt_pkg;
  localparam int MAX_ORDERS = 256;
  localparam int SLOT_W = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int SUM_W = 48;

  localparam logic [2:0] FUNC_REST   = 3'd0;
  localparam logic [2:0] FUNC_CANCEL = 3'd1;
  localparam logic [2:0] FUNC_REDUCE = 3'd2;
  localparam logic [2:0] FUNC_TOP    = 3'd3;
  localparam logic [2:0] FUNC_LEVEL  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;
  localparam logic [2:0] ST_OVER      = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             removed_side;
    logic [31:0]      removed_price;
    logic [31:0]      removed_quantity;
    logic             has_bid;
    logic [31:0]      bid_price;
    logic [SUM_W-1:0] bid_total;
    logic             has_ask;
    logic [31:0]      ask_price;
    logic [SUM_W-1:0] ask_total;
    logic [SUM_W-1:0] level_total;
  } rsp_t;

  // token passed down the cell chain; each cell folds its own slot into it
  typedef struct packed {
    logic              id_hit;
    logic [31:0]       hit_price;
    logic              hit_side;
    logic [31:0]       hit_qty;
    logic              free_hit;
    logic [SLOT_W-1:0] free_idx;
    logic              has_bid;
    logic [31:0]       bid_price;
    logic [SUM_W-1:0]  bid_total;
    logic              has_ask;
    logic [31:0]       ask_price;
    logic [SUM_W-1:0]  ask_total;
    logic [SUM_W-1:0]  level_total;
  } tok_t;

  // write command broadcast to all cells at the end of a request
  typedef struct packed {
    logic              wr;
    logic              by_idx;
    logic [SLOT_W-1:0] idx;
    logic              clear;
    logic [31:0]       id;
    logic              side;
    logic [31:0]       price;
    logic [31:0]       qty;
  } upd_t;
endpackage

### src/limit_order_book_table_top.sv
// limit_order_book_table_top: order book table with valid/stall channels
// depends on lobt_pkg, lobt_chain
//
// usage:
//   in_valid/in_stall/in_data carry one command request (lobt_pkg::req_t).
//   out_valid/out_stall/out_data carry its single result (lobt_pkg::rsp_t).
//   one request at a time: after acceptance the token walks the row of
//   MAX_ORDERS slot cells, one cell per cycle, then the done state checks
//   and writes the table and loads the result into the output register
//   once the output register is free; no new request is taken until then.
//   a new request can be taken while the previous result waits in the
//   output register.
//   reset empties the table (every slot invalid) and drops out_valid.
//   while out_stall is high the result holds; a finished request then
//   waits for the output register and no new request is taken.
module limit_order_book_table_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lobt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lobt_pkg::rsp_t out_data
);
  import lobt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;
  state_t state_r;
  req_t   req_r;
  tok_t   tok;
  upd_t   upd;
  rsp_t   rsp_nxt;
  logic   out_valid_r;
  logic   [SLOT_W-1:0] scan_cnt_r;
  logic   out_free;

  lobt_chain u_chain (.clk(clk), .rst_n(rst_n), .req(req_r), .upd(upd), .tok(tok));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    upd = '0;
    upd.id = req_r.order_id;
    upd.side = req_r.side;
    upd.price = req_r.price;
    upd.idx = tok.free_idx;
    rsp_nxt = '0;
    rsp_nxt.status = ST_OK;
    case (req_r.func)
      FUNC_REST: begin
        if (req_r.amount == 32'd0) rsp_nxt.status = ST_ZERO;
        else if (tok.id_hit) rsp_nxt.status = ST_DUP;
        else if (!tok.free_hit) rsp_nxt.status = ST_FULL;
        else begin
          upd.wr = 1'b1;
          upd.by_idx = 1'b1;
          upd.qty = req_r.amount;
        end
      end
      FUNC_CANCEL: begin
        if (!tok.id_hit) rsp_nxt.status = ST_NOT_FOUND;
        else begin
          rsp_nxt.removed_side = tok.hit_side;
          rsp_nxt.removed_price = tok.hit_price;
          rsp_nxt.removed_quantity = tok.hit_qty;
          upd.wr = 1'b1;
          upd.clear = 1'b1;
        end
      end
      FUNC_REDUCE: begin
        if (!tok.id_hit) rsp_nxt.status = ST_NOT_FOUND;
        else if (req_r.amount > tok.hit_qty) rsp_nxt.status = ST_OVER;
        else begin
          upd.wr = 1'b1;
          upd.qty = tok.hit_qty - req_r.amount;
          upd.clear = (tok.hit_qty == req_r.amount);
        end
      end
      FUNC_TOP: begin
        rsp_nxt.has_bid = tok.has_bid;
        rsp_nxt.bid_price = tok.has_bid ? tok.bid_price : 32'd0;
        rsp_nxt.bid_total = tok.has_bid ? tok.bid_total : '0;
        rsp_nxt.has_ask = tok.has_ask;
        rsp_nxt.ask_price = tok.has_ask ? tok.ask_price : 32'd0;
        rsp_nxt.ask_total = tok.has_ask ? tok.ask_total : '0;
      end
      FUNC_LEVEL: rsp_nxt.level_total = tok.level_total;
      default: ;
    endcase
    // write only in the cycle the result is loaded
    if (!(state_r == S_DONE && out_free)) upd.wr = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          req_r <= in_data;
          scan_cnt_r <= '0;
          state_r <= S_SCAN;
        end
        // the scan counter waits while the token walks to the end of the row
        S_SCAN: if (scan_cnt_r == SLOT_W'(MAX_ORDERS - 1)) begin
          state_r <= S_DONE;
        end else begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        S_DONE: if (out_free) begin
          out_data <= rsp_nxt;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### src/lobt_cell.sv
// lobt_cell: one table slot plus its combine stage in the scan chain
// depends on lobt_pkg
module lobt_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [lobt_pkg::SLOT_W-1:0] my_idx,
  input  lobt_pkg::req_t        req,
  input  lobt_pkg::upd_t        upd,
  input  lobt_pkg::tok_t        tok_in,
  output lobt_pkg::tok_t        tok_out
);
  import lobt_pkg::*;

  logic        valid_r;
  logic        side_r;
  logic [31:0] price_r, qty_r, id_r;
  logic        mine;
  tok_t        tok_nxt, tok_r;

  assign mine = upd.by_idx ? (upd.idx == my_idx) : (valid_r && id_r == upd.id);
  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (upd.wr && mine) begin
      valid_r <= !upd.clear;
      if (upd.by_idx) begin
        side_r  <= upd.side;
        price_r <= upd.price;
        id_r    <= upd.id;
      end
      qty_r <= upd.qty;
    end
  end

  // each cell folds its slot into the token and registers it, so the token
  // moves one cell per cycle down the row
  always_comb begin
    tok_nxt = tok_in;
    if (valid_r && id_r == req.order_id && !tok_in.id_hit) begin
      tok_nxt.id_hit    = 1'b1;
      tok_nxt.hit_price = price_r;
      tok_nxt.hit_side  = side_r;
      tok_nxt.hit_qty   = qty_r;
    end
    if (!valid_r && !tok_in.free_hit) begin
      tok_nxt.free_hit = 1'b1;
      tok_nxt.free_idx = my_idx;
    end
    if (valid_r && side_r == 1'b0) begin
      if (!tok_in.has_bid || price_r > tok_in.bid_price) begin
        tok_nxt.has_bid   = 1'b1;
        tok_nxt.bid_price = price_r;
        tok_nxt.bid_total = {{(SUM_W-32){1'b0}}, qty_r};
      end else if (price_r == tok_in.bid_price) begin
        tok_nxt.bid_total = tok_in.bid_total + {{(SUM_W-32){1'b0}}, qty_r};
      end
    end
    if (valid_r && side_r == 1'b1) begin
      if (!tok_in.has_ask || price_r < tok_in.ask_price) begin
        tok_nxt.has_ask   = 1'b1;
        tok_nxt.ask_price = price_r;
        tok_nxt.ask_total = {{(SUM_W-32){1'b0}}, qty_r};
      end else if (price_r == tok_in.ask_price) begin
        tok_nxt.ask_total = tok_in.ask_total + {{(SUM_W-32){1'b0}}, qty_r};
      end
    end
    if (valid_r && side_r == req.side && price_r == req.price) begin
      tok_nxt.level_total = tok_in.level_total + {{(SUM_W-32){1'b0}}, qty_r};
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end
endmodule

### src/lobt_chain.sv
// lobt_chain: row of slot cells, each registering the token it hands on
// depends on lobt_pkg, lobt_cell
module lobt_chain (
  input  logic           clk,
  input  logic           rst_n,
  input  lobt_pkg::req_t req,
  input  lobt_pkg::upd_t upd,
  output lobt_pkg::tok_t tok
);
  import lobt_pkg::*;

  tok_t links [MAX_ORDERS+1];
  tok_t seed;

  always_comb begin
    seed = '0;
  end
  assign links[0] = seed;

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lobt_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .my_idx(SLOT_W'(g)),
      .req(req), .upd(upd),
      .tok_in(links[g]), .tok_out(links[g+1])
    );
  end

  assign tok = links[MAX_ORDERS];
endmodule

### src/lobt_checker.sv
// lobt_checker: port-level assertions for the order book table
// depends on lobt_pkg; bound to limit_order_book_table_top
module lobt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input lobt_pkg::rsp_t out_data
);
  import lobt_pkg::*;

  // reset leaves the block idle with no result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall)) else $error("state after reset");

  // a request keeps the input busy while it walks the row of cells
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall [*MAX_ORDERS]) else $error("input not busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_OVER)) else $error("bad status");
endmodule

bind limit_order_book_table_top lobt_checker u_lobt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### tb/testbench.sv
// testbench: checks limit_order_book_table_top against an in-bench model of the book
// depends on lobt_pkg and limit_order_book_table_top
`timescale 1ns / 100ps

module testbench;
  import lobt_pkg::*;

  localparam int RANDOM_REQS = 140;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  limit_order_book_table_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // book model
  logic        bk_valid [MAX_ORDERS];
  logic        bk_side  [MAX_ORDERS];
  logic [31:0] bk_price [MAX_ORDERS];
  logic [31:0] bk_qty   [MAX_ORDERS];
  logic [31:0] bk_id    [MAX_ORDERS];

  rsp_t pending_rsp[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;
  logic [31:0] live_ids[$];

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < MAX_ORDERS; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [SUM_W-1:0] level_qty(logic sd, logic [31:0] pr);
    logic [SUM_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < MAX_ORDERS; i++)
      if (bk_valid[i] && bk_side[i] == sd && bk_price[i] == pr) sum += SUM_W'(bk_qty[i]);
    return sum;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int s;
    bit found;
    logic [31:0] best;
    o = '0;
    case (r.func)
      FUNC_REST: begin
        if (r.amount == 0) o.status = ST_ZERO;
        else if (find_slot(r.order_id) >= 0) o.status = ST_DUP;
        else begin
          s = -1;
          for (int i = 0; i < MAX_ORDERS; i++)
            if (!bk_valid[i]) begin s = i; break; end
          if (s < 0) o.status = ST_FULL;
          else begin
            bk_valid[s] = 1'b1; bk_side[s] = r.side; bk_price[s] = r.price;
            bk_qty[s] = r.amount; bk_id[s] = r.order_id;
          end
        end
      end
      FUNC_CANCEL: begin
        s = find_slot(r.order_id);
        if (s < 0) o.status = ST_NOT_FOUND;
        else begin
          o.removed_side = bk_side[s];
          o.removed_price = bk_price[s];
          o.removed_quantity = bk_qty[s];
          bk_valid[s] = 1'b0;
        end
      end
      FUNC_REDUCE: begin
        s = find_slot(r.order_id);
        if (s < 0) o.status = ST_NOT_FOUND;
        else if (r.amount > bk_qty[s]) o.status = ST_OVER;
        else begin
          bk_qty[s] -= r.amount;
          if (bk_qty[s] == 0) bk_valid[s] = 1'b0;
        end
      end
      FUNC_TOP: begin
        for (int sd = 0; sd < 2; sd++) begin
          found = 1'b0;
          best = '0;
          for (int i = 0; i < MAX_ORDERS; i++)
            if (bk_valid[i] && bk_side[i] == sd[0])
              if (!found || (sd == 0 && bk_price[i] > best) ||
                  (sd == 1 && bk_price[i] < best)) begin
                best = bk_price[i];
                found = 1'b1;
              end
          if (found && sd == 0) begin
            o.has_bid = 1'b1; o.bid_price = best; o.bid_total = level_qty(1'b0, best);
          end else if (found) begin
            o.has_ask = 1'b1; o.ask_price = best; o.ask_total = level_qty(1'b1, best);
          end
        end
      end
      FUNC_LEVEL: o.level_total = level_qty(r.side, r.price);
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t mk(logic [2:0] f, logic [31:0] id, logic sd,
                              logic [31:0] pr, logic [31:0] amt);
    req_t r;
    r.func = f; r.order_id = id; r.side = sd; r.price = pr; r.amount = amt;
    return r;
  endfunction

  // directed requests, with hand-typed results where obvious
  req_t dir_req[$];
  rsp_t dir_rsp[$];
  bit   dir_typed[$];

  task automatic add_row(req_t r, bit typed, rsp_t o);
    dir_req = {dir_req, r};
    dir_typed = {dir_typed, typed};
    dir_rsp = {dir_rsp, o};
  endtask

  task automatic send(req_t r, bit typed, rsp_t o);
    rsp_t p;
    while (quiet == 1'b0 && $urandom_range(99) < 31) @(negedge clk);
    p = apply_request(r);
    pending_rsp = {pending_rsp, (typed ? o : p)};
    in_valid = 1'b1;
    in_data = r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    in_data = '0;
  endtask

  function automatic req_t random_request();
    int pick;
    logic [31:0] id;
    logic [31:0] pr;
    pick = $urandom_range(99);
    id = (live_ids.size() > 0 && $urandom_range(3) != 0) ?
         live_ids[$urandom_range(live_ids.size() - 1)] : $urandom_range(63);
    if ($urandom_range(9) == 0) id = $urandom();
    pr = ($urandom_range(7) == 0) ? $urandom() : 32'd1000 + $urandom_range(15);
    if (pick < 40) begin
      if (live_ids.size() < 300) live_ids = {live_ids, id};
      return mk(FUNC_REST, id, 1'($urandom_range(1)), pr,
                ($urandom_range(15) == 0) ? $urandom() : $urandom_range(50));
    end
    if (pick < 55) return mk(FUNC_CANCEL, id, 1'($urandom_range(1)), $urandom(), $urandom());
    if (pick < 72) return mk(FUNC_REDUCE, id, 1'($urandom_range(1)), $urandom(),
                             ($urandom_range(15) == 0) ? $urandom() : $urandom_range(30));
    if (pick < 84) return mk(FUNC_TOP, $urandom(), 1'($urandom_range(1)), $urandom(), $urandom());
    if (pick < 96) return mk(FUNC_LEVEL, $urandom(), 1'($urandom_range(1)), pr, $urandom());
    return mk(3'($urandom_range(7, 5)), $urandom(), 1'($urandom_range(1)), $urandom(),
              $urandom());
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(negedge clk) begin
    if (rst_n) out_stall <= (quiet == 1'b0) && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("limit_order_book_table_top verification failed");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data !== pending_rsp[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", pending_rsp[0], out_data);
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  initial begin
    rsp_t z;
    rsp_t t;
    int waited;
    z = '0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      bk_valid[i] = 1'b0; bk_side[i] = 1'b0; bk_price[i] = '0;
      bk_qty[i] = '0; bk_id[i] = '0;
    end

    // empty book, then extremes
    add_row(mk(FUNC_TOP, 32'hFFFF_FFFF, 1'b1, '1, '1), 1'b1, z);
    add_row(mk(FUNC_CANCEL, 32'd7, 1'b0, '0, '0), 1'b1, '{status: ST_NOT_FOUND, default: '0});
    add_row(mk(FUNC_REDUCE, 32'd7, 1'b0, '0, 32'd1), 1'b1,
            '{status: ST_NOT_FOUND, default: '0});
    t = z; t.status = ST_ZERO;
    add_row(mk(FUNC_REST, 32'd1, 1'b0, 32'd5, '0), 1'b1, t);
    add_row(mk(FUNC_REST, 32'd1, 1'b0, '1, '1), 1'b1, z);
    add_row(mk(FUNC_REST, 32'hFFFF_FFFF, 1'b0, '1, '1), 1'b1, z);
    t = z; t.status = ST_DUP;
    add_row(mk(FUNC_REST, 32'd1, 1'b1, 32'd3, 32'd3), 1'b1, t);
    add_row(mk(FUNC_REST, 32'd0, 1'b1, '0, '1), 1'b1, z);
    add_row(mk(FUNC_REST, 32'd2, 1'b1, 32'd0, 32'd9), 1'b1, z);
    add_row(mk(FUNC_TOP, '0, 1'b0, '0, '0), 1'b0, z);
    add_row(mk(FUNC_LEVEL, '0, 1'b0, '1, '0), 1'b0, z);
    t = z; t.status = ST_OVER;
    add_row(mk(FUNC_REDUCE, 32'd2, 1'b0, '0, 32'd10), 1'b1, t);
    add_row(mk(FUNC_REDUCE, 32'd2, 1'b0, '0, 32'd0), 1'b1, z);
    add_row(mk(FUNC_REDUCE, 32'd2, 1'b0, '0, 32'd9), 1'b1, z);
    add_row(mk(FUNC_CANCEL, 32'hFFFF_FFFF, 1'b0, '0, '0), 1'b0, z);
    add_row(mk(3'd5, '1, 1'b1, '1, '1), 1'b1, z);
    add_row(mk(3'd6, '1, 1'b1, '1, '1), 1'b1, z);
    add_row(mk(3'd7, '1, 1'b1, '1, '1), 1'b1, z);
    add_row(mk(FUNC_TOP, '0, 1'b0, '0, '0), 1'b0, z);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_req[i]) send(dir_req[i], dir_typed[i], dir_rsp[i]);

    // fill the table to flag full, then cancel every second order
    for (int i = 0; i < MAX_ORDERS + 2; i++)
      send(mk(FUNC_REST, 32'h1000 + i, i[0], 32'd500 + i[3:0], 32'd1 + i), 1'b0, z);
    send(mk(FUNC_TOP, '0, 1'b0, '0, '0), 1'b0, z);
    for (int i = 0; i < MAX_ORDERS + 2; i += 2)
      send(mk(FUNC_CANCEL, 32'h1000 + i, 1'b0, '0, '0), 1'b0, z);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      quiet = (n >= 40 && n < 100);
      send(random_request(), 1'b0, z);
    end
    quiet = 1'b0;

    waited = 0;
    while (pending_rsp.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("limit_order_book_table_top verification clean");
    else
      $display("limit_order_book_table_top verification failed");
    $finish;
  end
endmodule
